### rtl/lpsd_pkg.sv
// shared types, constants and header decode for the length prefix deframer
package lpsd_pkg;

    localparam int unsigned LEN_W = 31;

    localparam logic [31:0]      NEW_FORMAT_BIT  = 32'h8000_0000;
    localparam logic [31:0]      NEW_LENGTH_MASK = 32'h0000_FFF0;
    localparam logic [LEN_W-1:0] HEADER_LEN      = 31'd4;

    typedef enum logic [2:0] {
        ST_HDR0,
        ST_HDR1,
        ST_HDR2,
        ST_HDR3,
        ST_PAYLOAD,
        ST_ERROR
    } lpsd_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       first_of_packet;
        logic       last_of_packet;
        logic       bad_length;
    } lpsd_result_t;

    // bit 31 clear: 31-bit length, set: 12-bit length in bits 15..4
    function automatic logic [LEN_W-1:0] decode_length(input logic [31:0] word);
        logic [31:0] masked;
        masked = word & NEW_LENGTH_MASK;
        if ((word & NEW_FORMAT_BIT) == 32'd0)
        begin
            return word[LEN_W-1:0];
        end
        return {19'd0, masked[15:4]};
    endfunction

endpackage

### rtl/lpsd_frame_ctrl.sv
// framing state machine: header capture, length decode, payload count, sticky error
module lpsd_frame_ctrl
    import lpsd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  logic [7:0]              data_byte,
    output logic                    res_valid,
    output lpsd_result_t            res
);

    lpsd_state_t              state_reg, state_next;
    logic [23:0]              header_reg, header_next;
    logic [LEN_W-1:0]         remain_reg, remain_next;
    logic [31:0]              word;
    logic [LEN_W-1:0]         len;

    assign word = {data_byte, header_reg};
    assign len  = decode_length(word);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_HDR0;
            header_reg <= '0;
            remain_reg <= '0;
        end
        else if (fire)
        begin
            state_reg  <= state_next;
            header_reg <= header_next;
            remain_reg <= remain_next;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        header_next         = header_reg;
        remain_next         = remain_reg;
        res_valid           = 1'b1;
        res.out_byte        = data_byte;
        res.first_of_packet = 1'b0;
        res.last_of_packet  = 1'b0;
        res.bad_length      = 1'b0;
        unique case (state_reg)
            ST_HDR0:
            begin
                res.first_of_packet = 1'b1;
                header_next         = header_reg | {16'd0, data_byte};
                state_next          = ST_HDR1;
            end
            ST_HDR1:
            begin
                header_next = header_reg | {8'd0, data_byte, 8'd0};
                state_next  = ST_HDR2;
            end
            ST_HDR2:
            begin
                header_next = header_reg | {data_byte, 16'd0};
                state_next  = ST_HDR3;
            end
            ST_HDR3:
            begin
                if (len <= HEADER_LEN)
                begin
                    res.bad_length     = 1'b1;
                    res.last_of_packet = 1'b1;
                    state_next         = ST_ERROR;
                end
                else
                begin
                    remain_next = len - HEADER_LEN;
                    state_next  = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD:
            begin
                if (remain_reg <= 31'd1)
                begin
                    remain_next        = '0;
                    header_next        = '0;
                    res.last_of_packet = 1'b1;
                    state_next         = ST_HDR0;
                end
                else
                begin
                    remain_next = remain_reg - 31'd1;
                end
            end
            ST_ERROR:
            begin
                // every item dropped until reset
                res_valid = 1'b0;
            end
            default:
            begin
                res_valid  = 1'b0;
                state_next = ST_ERROR;
            end
        endcase
    end

endmodule

### rtl/length_prefix_stream_deframer_core.sv
// length prefix deframer: input register, framing logic and result register
// an accepted byte passes through the input register and then the result register before out_valid rises
// throughput: one byte per cycle while out_stall is low, limited by the single result register
// in_stall rises only while the input register is full and a held result is stalled
// reset (rst_n low, asynchronous) empties both registers and clears header,
// count and sticky error; the block can take items once reset is released
module length_prefix_stream_deframer_core
    import lpsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       first_of_packet,
    output logic       last_of_packet,
    output logic       bad_length
);

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg, out_valid_next;
    lpsd_result_t out_reg;
    logic         accept;
    logic         advance;
    logic         res_valid;
    lpsd_result_t res;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    lpsd_frame_ctrl u_frame_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .data_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res_valid;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= data_byte;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_byte        = out_reg.out_byte;
    assign first_of_packet = out_reg.first_of_packet;
    assign last_of_packet  = out_reg.last_of_packet;
    assign bad_length      = out_reg.bad_length;

endmodule

### rtl/lpsd_checker.sv
// port-level checks for the length prefix deframer, bound to the top level
module lpsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       first_of_packet,
    input logic       last_of_packet,
    input logic       bad_length
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(last_of_packet) && $stable(bad_length))
        else $error("stalled result changed");

    // a bad length always closes the packet and never sits on a first byte
    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_length |-> last_of_packet && !first_of_packet)
        else $error("bad length without last mark");

    // the first header byte can never also end a packet
    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && first_of_packet |-> !last_of_packet)
        else $error("first and last on one item");

    // after a bad length leaves, nothing follows
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && bad_length |=> !out_valid)
        else $error("result after bad length");

endmodule

bind length_prefix_stream_deframer_core lpsd_checker u_lpsd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .first_of_packet (first_of_packet),
    .last_of_packet  (last_of_packet),
    .bad_length      (bad_length)
);
